FILE: hw/rtl/lrg_pkg.sv
// ---------------------------------------------------------------------------
// lrg_pkg: shared types and helpers for the leaky ReLU bf16 gradient block
// Holds the per-lane product record and the leading-one search.
// ---------------------------------------------------------------------------
`default_nettype none
package lrg_pkg;

	localparam int unsigned LANE_W   = 16;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned PROD_W   = 32;
	localparam int unsigned EXP_W    = 9;
	localparam logic [15:0] BF16_QNAN = 16'h7FC0;
	localparam logic [15:0] BF16_INF  = 16'h7F80;
	localparam logic [15:0] BF16_MAXF = 16'h7F80;

	// Per-lane record between the multiply stage and the rounding stage
	typedef struct packed {
		logic                  pass;   // forward output > 0, gradient passes
		logic [LANE_W-1:0]     grad;   // raw gradient for the pass case
		logic                  sign;
		logic                  nan;
		logic                  inf;
		logic [PROD_W-1:0]     prod;   // exact significand product
		logic [EXP_W-1:0]      esum;   // sum of effective biased exponents
	} prod_t;

	// Position of the leading one (0 when the word is zero)
	function automatic logic [4:0] lead_one(input logic [PROD_W-1:0] v);
		logic [4:0] pos;
		pos = '0;
		for (int i = 0; i < PROD_W; i++) begin
			if (v[i]) begin
				pos = 5'(i);
			end
		end
		return pos;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/leaky_relu_grad_bf16.sv
// ---------------------------------------------------------------------------
// leaky_relu_grad_bf16: leaky ReLU backward pass on packed bf16 pairs
// Passes each lane's gradient where the forward output is positive, else
// scales it by the fp32 slope and rounds back to bf16.
// ---------------------------------------------------------------------------
// Channel  Handshake              Payload
// in       in_valid / in_ready    out_word, grad_word, is_last
// out      out_valid / out_ready  in_grad_word, last_out
// cfg      cfg_valid / cfg_ready  slope
//
// One transaction per cycle sustained while out accepts; three registers (input
// register, product register, result register) advance together whenever
// the result register is empty or taken, so a stall on out holds the whole
// pipe. Reset clears the valid bits and loads slope with 0.01.
// ---------------------------------------------------------------------------
`default_nettype none
module leaky_relu_grad_bf16 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] out_word,
	input  wire logic [31:0] grad_word,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      in_grad_word,
	output logic             last_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] slope
);
	import lrg_pkg::*;

	logic        en;
	logic        valid_s1, valid_s2;
	logic [31:0] fwd_s1, grad_s1;
	logic        last_s1, last_s2;
	logic [31:0] slope_q;
	prod_t       prod_lo, prod_hi, prod_lo_s2, prod_hi_s2;
	logic [15:0] res_lo, res_hi;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// Slope register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q <= 32'h3C23D70A;
		end else if (cfg_valid) begin
			slope_q <= slope;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	// Multiply both lanes
	lrg_lane_mul u_mul_lo (
		.fwd(fwd_s1[15:0]), .grad(grad_s1[15:0]), .slope(slope_q), .prod(prod_lo)
	);
	lrg_lane_mul u_mul_hi (
		.fwd(fwd_s1[31:16]), .grad(grad_s1[31:16]), .slope(slope_q), .prod(prod_hi)
	);

	// Round both lanes
	lrg_lane_round u_rnd_lo (.prod(prod_lo_s2), .res(res_lo));
	lrg_lane_round u_rnd_hi (.prod(prod_hi_s2), .res(res_hi));

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			fwd_s1       <= out_word;
			grad_s1      <= grad_word;
			last_s1      <= is_last;
			prod_lo_s2   <= prod_lo;
			prod_hi_s2   <= prod_hi;
			last_s2      <= last_s1;
			in_grad_word <= {res_hi, res_lo};
			last_out     <= last_s2;
		end
	end

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && en |=> valid_s2)
		else $error("stage 1 transaction lost");
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en |=> out_valid)
		else $error("stage 2 transaction lost");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

endmodule
`default_nettype wire

FILE: hw/rtl/lrg_lane_mul.sv
// ---------------------------------------------------------------------------
// lrg_lane_mul: per-lane compare and significand multiply
// Classifies the operands and forms the exact bf16 x fp32 product.
// ---------------------------------------------------------------------------
`default_nettype none
module lrg_lane_mul (
	input  wire logic [15:0]   fwd,
	input  wire logic [15:0]   grad,
	input  wire logic [31:0]   slope,
	output lrg_pkg::prod_t     prod
);
	import lrg_pkg::*;

	logic [7:0]  ea, eb;
	logic [6:0]  fa;
	logic [22:0] fb;
	logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
	logic [7:0]  ma;
	logic [23:0] mb;

	// Unpack operands
	assign ea = grad[14:7];
	assign fa = grad[6:0];
	assign eb = slope[30:23];
	assign fb = slope[22:0];

	// Classify
	assign a_nan  = (ea == 8'hFF) && (fa != '0);
	assign a_inf  = (ea == 8'hFF) && (fa == '0);
	assign a_zero = (ea == 8'h00) && (fa == '0);
	assign b_nan  = (eb == 8'hFF) && (fb != '0);
	assign b_inf  = (eb == 8'hFF) && (fb == '0);
	assign b_zero = (eb == 8'h00) && (fb == '0);

	assign ma = {ea != 8'h00, fa};
	assign mb = {eb != 8'h00, fb};

	// Build the lane record
	always_comb begin
		prod.pass = !fwd[15] && (fwd != '0) && (fwd <= BF16_MAXF);
		prod.grad = grad;
		prod.sign = grad[15] ^ slope[31];
		prod.nan  = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
		prod.inf  = (a_inf || b_inf) && !prod.nan;
		prod.prod = PROD_W'(ma) * PROD_W'(mb);
		prod.esum = EXP_W'((ea == 8'h00) ? 8'd1 : ea) + EXP_W'((eb == 8'h00) ? 8'd1 : eb);
	end

endmodule
`default_nettype wire

FILE: hw/rtl/lrg_lane_round.sv
// ---------------------------------------------------------------------------
// lrg_lane_round: per-lane normalize and round
// Rounds the exact product to fp32 (subnormals kept), then to bf16, RNE both.
// ---------------------------------------------------------------------------
`default_nettype none
module lrg_lane_round (
	input  lrg_pkg::prod_t     prod,
	output logic [15:0]        res
);
	import lrg_pkg::*;

	logic [4:0]         lead;
	logic signed [10:0] r_norm, r_sub, rsh, ex, ebase;
	logic [5:0]         rs;
	logic [65:0]        shifted;
	logic [24:0]        m, mr;
	logic               rnd, sticky;
	logic [33:0]        mag;
	logic [31:0]        f32;
	logic [32:0]        bsum;

	assign lead   = lead_one(prod.prod);
	assign r_norm = $signed({6'b0, lead}) - 11'sd23;
	assign r_sub  = 11'sd135 - $signed({2'b0, prod.esum});
	assign rsh    = (r_norm > r_sub) ? r_norm : r_sub;
	assign ex     = $signed({6'b0, lead}) + $signed({2'b0, prod.esum}) - 11'sd157;
	assign ebase  = (ex >= 11'sd1) ? (ex - 11'sd1) : 11'sd0;

	// Align the product to the fp32 significand grid
	always_comb begin
		rs      = (rsh > 11'sd34) ? 6'd34 : ((rsh > 11'sd0) ? rsh[5:0] : 6'd0);
		shifted = {prod.prod, 34'b0} >> rs;
		if (rsh <= 11'sd0) begin
			m      = 25'(prod.prod) << (-rsh);
			rnd    = 1'b0;
			sticky = 1'b0;
		end else begin
			m      = shifted[58:34];
			rnd    = shifted[33];
			sticky = |shifted[32:0];
		end
		mr  = m + 25'(rnd && (sticky || m[0]));
		mag = ({23'b0, ebase} << 23) + 34'(mr);
		if ((ex >= 11'sd255) || (mag >= 34'h07F800000)) begin
			mag = 34'h07F800000;
		end
		f32  = {prod.sign, mag[30:0]};
		bsum = 33'(f32) + 33'h7FFF + 33'(f32[16]);
	end

	// Select the lane result
	always_comb begin
		priority if (prod.pass) begin
			res = prod.grad;
		end else if (prod.nan) begin
			res = BF16_QNAN;
		end else if (prod.inf) begin
			res = {prod.sign, BF16_INF[14:0]};
		end else if (prod.prod == '0) begin
			res = {prod.sign, 15'b0};
		end else begin
			res = bsum[31:16];
		end
	end

endmodule
`default_nettype wire

FILE: tb/lrg_checker.sv
// ---------------------------------------------------------------------------
// lrg_checker: scoreboard for the leaky ReLU bf16 gradient block
// Watches the in, out and cfg channels, predicts each packed gradient word
// from its own copy of the slope, and compares results in order.
// ---------------------------------------------------------------------------
`default_nettype none
module lrg_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [31:0] out_word,
	input  wire logic [31:0] grad_word,
	input  wire logic        is_last,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] in_grad_word,
	input  wire logic        last_out,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [31:0] slope,
	output int               fail_count,
	output int               pending
);
	import lrg_pkg::*;

	localparam logic [31:0] SLOPE_RESET = 32'h3C23D70A;
	localparam logic [31:0] F32_INF     = 32'h7F800000;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} grad_rec_t;

	grad_rec_t   grad_q[$];
	logic [31:0] slope_q;
	int          fails;

	assign fail_count = fails;
	assign pending    = grad_q.size();

	function automatic logic out_positive(input logic [15:0] b);
		return !b[15] && b != 16'h0 && b <= BF16_INF;
	endfunction

	// fp32 multiply with round-to-nearest-even, subnormals kept
	function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
		logic        sgn, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		int          ea, eb, lead, e_norm, sh;
		logic [63:0] prod, m, rem, half;
		logic [63:0] bits;
		sgn    = a[31] ^ b[31];
		a_nan  = a[30:23] == 8'hFF && a[22:0] != 0;
		b_nan  = b[30:23] == 8'hFF && b[22:0] != 0;
		a_inf  = a[30:23] == 8'hFF && a[22:0] == 0;
		b_inf  = b[30:23] == 8'hFF && b[22:0] == 0;
		a_zero = a[30:0] == 0;
		b_zero = b[30:0] == 0;
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
			return 32'h7FC00000;
		end
		if (a_inf || b_inf) begin
			return {sgn, F32_INF[30:0]};
		end
		if (a_zero || b_zero) begin
			return {sgn, 31'h0};
		end
		ea   = (a[30:23] == 0) ? 1 : int'(a[30:23]);
		eb   = (b[30:23] == 0) ? 1 : int'(b[30:23]);
		prod = 64'({(a[30:23] != 0), a[22:0]}) * 64'({(b[30:23] != 0), b[22:0]});
		lead = 0;
		for (int i = 0; i < 48; i++) begin
			if (prod[i]) begin
				lead = i;
			end
		end
		e_norm = lead + ea + eb - 173;
		sh     = (e_norm >= 1) ? lead - 23 : 151 - ea - eb;
		// shift down to the kept significand and round half to even
		if (sh <= 0) begin
			m = prod << (-sh);
		end else if (sh >= 60) begin
			m = 0;
		end else begin
			m    = prod >> sh;
			rem  = prod & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && m[0])) begin
				m = m + 1;
			end
		end
		if (e_norm >= 1) begin
			bits = (64'(e_norm - 1) << 23) + m;
		end else begin
			bits = m;
		end
		if (bits >= 64'(F32_INF)) begin
			bits = 64'(F32_INF);
		end
		return {sgn, bits[30:0]};
	endfunction

	function automatic logic [15:0] lane_in_grad(input logic [15:0] o, input logic [15:0] g,
		input logic [31:0] s);
		logic [31:0] p;
		if (out_positive(o)) begin
			return g;
		end
		p = f32_mul({g, 16'h0}, s);
		if (p[30:23] == 8'hFF && p[22:0] != 0) begin
			return BF16_QNAN;
		end
		p = p + 32'h7FFF + {31'h0, p[16]};
		return p[31:16];
	endfunction

	// track slope, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		grad_rec_t exp_r;
		if (!arst_n) begin
			slope_q = SLOPE_RESET;
			grad_q.delete();
			fails   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				slope_q = slope;
			end
			if (in_valid && in_ready) begin
				exp_r.word = {lane_in_grad(out_word[31:16], grad_word[31:16], slope_q),
				              lane_in_grad(out_word[15:0], grad_word[15:0], slope_q)};
				exp_r.last = is_last;
				grad_q.push_back(exp_r);
			end
			if (out_valid && out_ready) begin
				if (grad_q.size() == 0) begin
					$display("%0t: unexpected transaction in_grad_word=%h last_out=%b",
					         $time, in_grad_word, last_out);
					fails = fails + 1;
				end else begin
					exp_r = grad_q.pop_front();
					if (in_grad_word !== exp_r.word) begin
						$display("%0t: in_grad_word expected %h actual %h",
						         $time, exp_r.word, in_grad_word);
						fails = fails + 1;
					end
					if (last_out !== exp_r.last) begin
						$display("%0t: last_out expected %b actual %b",
						         $time, exp_r.last, last_out);
						fails = fails + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the leaky ReLU bf16 gradient block
// Drives directed and random bf16 pairs under several slope settings and
// idle patterns; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none
module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] out_word = '0;
	logic [31:0] grad_word = '0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] in_grad_word;
	logic        last_out;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] slope = '0;
	int          fail_count, pending;
	int          tx_idle = 0;
	int          rx_idle = 0;
	int          n_items = 0;
	int          n_cfg = 0;

	always #6 clk = ~clk;

	leaky_relu_grad_bf16 dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_word(out_word), .grad_word(grad_word), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.in_grad_word(in_grad_word), .last_out(last_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .slope(slope)
	);

	lrg_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_word(out_word), .grad_word(grad_word), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.in_grad_word(in_grad_word), .last_out(last_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .slope(slope),
		.fail_count(fail_count), .pending(pending)
	);

	// stall the result side at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle);
	end

	// pick a bf16 value, weighted toward the special encodings
	function automatic logic [15:0] pick_bf16();
		logic [15:0] v;
		v = 16'($urandom());
		case ($urandom_range(0, 9))
			0: v = {v[15], 15'h0};
			1: v = {v[15], 8'hFF, 7'h0};
			2: v = {v[15], 8'hFF, (v[6:0] == 0) ? 7'h1 : v[6:0]};
			3: v = {v[15], 8'h00, v[6:0]};
			4: v = {v[15], 8'hFE, v[6:0]};
			default: ;
		endcase
		return v;
	endfunction

	// present one transaction; valid stays high into the next call
	task automatic send_pair(input logic [31:0] ow, input logic [31:0] gw, input logic l);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		out_word  <= ow;
		grad_word <= gw;
		is_last   <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_items = n_items + 1;
	endtask

	// drain the pipe, then write the slope
	task automatic load_slope(input logic [31:0] s);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		slope     <= s;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_cfg = n_cfg + 1;
	endtask

	task automatic random_burst(input int count);
		for (int i = 0; i < count; i++) begin
			case (i * 3 / count)
				0: begin tx_idle = 21; rx_idle = 46; end
				1: begin tx_idle = 46; rx_idle = 21; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			send_pair({pick_bf16(), pick_bf16()}, {pick_bf16(), pick_bf16()},
			          ($urandom_range(0, 15) == 0));
		end
	endtask

	initial begin
		logic [31:0] slopes [6];
		slopes = '{32'h00000000, 32'hFFFFFFFF, 32'h7F7FFFFF, 32'h00000001,
		           32'h7F800000, 32'hBF000000};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zeros, infinities, NaN, subnormals, extremes, last marker
		send_pair(32'h0000_8000, 32'hFFFF_0001, 1'b0);
		send_pair(32'h7F80_7FC0, 32'h7F80_FF80, 1'b1);
		send_pair(32'h3F80_BF80, 32'h7F7F_FF7F, 1'b0);
		send_pair(32'hFFFF_0001, 32'h0001_8001, 1'b1);
		send_pair(32'h8001_7F81, 32'h7FC0_0000, 1'b0);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_pair(32'h7F7F_0080, 32'h3F81_C0C1, 1'b0);
		random_burst(300);

		// slope extremes: zero, NaN, max, min subnormal, infinity, negative
		foreach (slopes[k]) begin
			load_slope(slopes[k]);
			send_pair(32'h0000_8000, 32'h7F80_0001, 1'b0);
			send_pair(32'hFFFF_7FC0, 32'h7F7F_FF7F, 1'b1);
			send_pair(32'h8000_0000, 32'h0000_8000, 1'b0);
			random_burst(120);
		end
		load_slope($urandom());
		random_burst(200);
		load_slope(32'h3C23D70A);
		random_burst(150);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Covered %0d bf16 pair transactions over %0d slope writes,", n_items, n_cfg);
		$display("with specials, subnormals, overflow and both idle patterns.");
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#(12 * 400000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
